/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CELL_W      = 16;

  // first cell of the bottom row, also the length of the scroll copy
  localparam int SCROLL_END  = CELL_COUNT - SCREEN_COLS;
  localparam int LAST_CELL   = CELL_COUNT - 1;

  // character and attribute codes
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd15;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_code_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCROLL,
    ST_PUT,
    ST_RDWAIT,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_cmd_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
  } tcw_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tcw_ram_req_t;

endpackage

`default_nettype wire

/* rtl/tcw_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface tcw_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, req_type, char_code, read_row, read_col, input ready);
  modport sink   (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

// result channel
interface tcw_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic [4:0] cursor_row_out;
  logic [6:0] cursor_col_out;

  modport source (output valid, cell_char, cell_attr, cursor_row_out, cursor_col_out,
                  input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_row_out, cursor_col_out,
                  output ready);
endinterface

`default_nettype wire

/* rtl/tcw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire              clk,
  input  wire              we,
  input  wire  [AW-1:0]    waddr,
  input  wire  [WIDTH-1:0] wdata,
  input  wire              re,
  input  wire  [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/tcw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire  [7:0]        text_attribute,
  input  wire               cmd_valid,
  output logic              cmd_ready,
  input  wire  tcw_cmd_t    cmd,
  output tcw_ram_req_t      ram,
  input  wire  [CELL_W-1:0] ram_rdata,
  input  wire               slot_free,
  output logic              res_load,
  output tcw_res_t          res
);

  tcw_state_t        st, st_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic              fill_init, init_next;
  logic              put_pend, pend_next;
  logic [7:0]        code_q, code_next;
  logic [4:0]        row, row_next;
  logic [6:0]        col, col_next;
  logic [7:0]        res_char, char_next;
  logic [7:0]        res_attr, attr_next;
  logic              go_line;

  // linear cell address of a row and column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] r, input logic [6:0] c);
    cell_addr = ADDR_W'(int'(r) * SCREEN_COLS + int'(c));
  endfunction

  // state and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_FILL;
      cnt       <= '0;
      fill_init <= 1'b1;
      put_pend  <= 1'b0;
      row       <= '0;
      col       <= '0;
    end else begin
      st        <= st_next;
      cnt       <= cnt_next;
      fill_init <= init_next;
      put_pend  <= pend_next;
      row       <= row_next;
      col       <= col_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_q   <= code_next;
    res_char <= char_next;
    res_attr <= attr_next;
  end

  // sequencer
  always_comb begin
    st_next   = st;
    cnt_next  = cnt;
    init_next = fill_init;
    pend_next = put_pend;
    code_next = code_q;
    row_next  = row;
    col_next  = col;
    char_next = res_char;
    attr_next = res_attr;
    ram       = '0;
    cmd_ready = 1'b0;
    res_load  = 1'b0;
    go_line   = 1'b0;

    unique case (st)
      ST_FILL: begin
        ram.we    = 1'b1;
        ram.waddr = cnt;
        ram.wdata = {(fill_init ? ATTR_RESET : text_attribute), CODE_SPACE};
        if (cnt == ADDR_W'(LAST_CELL)) begin
          init_next = 1'b0;
          if (fill_init) begin
            st_next = ST_IDLE;
          end else if (put_pend) begin
            st_next = ST_PUT;
          end else begin
            st_next = ST_DONE;
          end
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          char_next = '0;
          attr_next = '0;
          pend_next = 1'b0;
          code_next = cmd.char_code;
          case (cmd.req_type)
            REQ_PUT: begin
              if (cmd.char_code == CODE_NEWLINE) begin
                go_line = 1'b1;
              end else if (int'(col) >= SCREEN_COLS) begin
                pend_next = 1'b1;
                go_line   = 1'b1;
              end else begin
                st_next = ST_PUT;
              end
            end
            REQ_CLEAR: begin
              row_next = '0;
              col_next = '0;
              cnt_next = '0;
              st_next  = ST_FILL;
            end
            REQ_READ: begin
              if (int'(cmd.read_row) < SCREEN_ROWS && int'(cmd.read_col) < SCREEN_COLS) begin
                ram.re    = 1'b1;
                ram.raddr = cell_addr(cmd.read_row, cmd.read_col);
                st_next   = ST_RDWAIT;
              end else begin
                st_next = ST_DONE;
              end
            end
            default: begin
              st_next = ST_DONE;
            end
          endcase
        end
      end

      // copy one cell up a row per cycle, each write trailing the registered read
      ST_SCROLL: begin
        if (cnt != ADDR_W'(SCROLL_END)) begin
          ram.re    = 1'b1;
          ram.raddr = ADDR_W'(int'(cnt) + SCREEN_COLS);
        end
        if (cnt != '0) begin
          ram.we    = 1'b1;
          ram.waddr = cnt - ADDR_W'(1);
          ram.wdata = ram_rdata;
        end
        if (cnt == ADDR_W'(SCROLL_END)) begin
          st_next = ST_FILL;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end

      ST_PUT: begin
        ram.we    = 1'b1;
        ram.waddr = cell_addr(row, col);
        ram.wdata = {text_attribute, code_q};
        col_next  = col + 7'd1;
        pend_next = 1'b0;
        st_next   = ST_DONE;
      end

      ST_RDWAIT: begin
        char_next = ram_rdata[7:0];
        attr_next = ram_rdata[15:8];
        st_next   = ST_DONE;
      end

      ST_DONE: begin
        if (slot_free) begin
          res_load = 1'b1;
          st_next  = ST_IDLE;
        end
      end

      default: begin
        st_next = ST_IDLE;
      end
    endcase

    // move to the next line, scrolling from the last row
    if (go_line) begin
      col_next = '0;
      if (int'(row) + 1 < SCREEN_ROWS) begin
        row_next = row + 5'd1;
        st_next  = pend_next ? ST_PUT : ST_DONE;
      end else begin
        cnt_next = '0;
        st_next  = ST_SCROLL;
      end
    end
  end

  assign res.cell_char      = res_char;
  assign res.cell_attr      = res_attr;
  assign res.cursor_row_out = row;
  assign res.cursor_col_out = col;

  // cursor stays on the screen, column at most one past the last
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    int'(col) <= SCREEN_COLS)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    int'(row) < SCREEN_ROWS)
    else $error("cursor row out of range");

  // the store is never written while waiting for a word
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (st == ST_IDLE || st == ST_DONE) |-> !ram.we)
    else $error("store written while idle");

  // an accepted word blocks the next one
  a_one_at_once: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("second word accepted during work");

  // a result is handed over once per word
  a_single_load: assert property (@(posedge clk) disable iff (rst)
    res_load |=> !res_load)
    else $error("result loaded twice");

endmodule

`default_nettype wire

/* rtl/text_console_writer_top.sv */
// accepted word to result, by state: read IDLE, RDWAIT, DONE; put IDLE, PUT, DONE; newline
// IDLE, DONE; put after a wrap IDLE, PUT, DONE; on the bottom row a newline or wrap runs
// SCROLL, a FILL of the bottom row, PUT for a put, then DONE; clear runs a FILL of the store
// then DONE; one word in work at a time, the next taken the cycle after the result loads;
// a result register lets the next word in while the last result waits
// reset: synchronous, clears cursor, sets attribute to ATTR_RESET, then a pass fills the store
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top
  import tcw_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  tcw_cmd_if.sink     cmd,
  tcw_rsp_if.source   rsp,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data
);

  logic [7:0]    text_attribute;
  tcw_cmd_t      cmd_word;
  tcw_ram_req_t  ram;
  logic [CELL_W-1:0] ram_rdata;
  logic          slot_free;
  logic          res_load;
  tcw_res_t      res;
  logic          out_valid;
  tcw_res_t      out_word;

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (cfg_wr_en) begin
      text_attribute <= cfg_wr_data;
    end
  end

  assign cmd_word.req_type  = cmd.req_type;
  assign cmd_word.char_code = cmd.char_code;
  assign cmd_word.read_row  = cmd.read_row;
  assign cmd_word.read_col  = cmd.read_col;

  tcw_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .text_attribute (text_attribute),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd            (cmd_word),
    .ram            (ram),
    .ram_rdata      (ram_rdata),
    .slot_free      (slot_free),
    .res_load       (res_load),
    .res            (res)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT),
    .AW    (ADDR_W)
  ) u_cells (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (ram_rdata)
  );

  // result register
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.cell_char      = out_word.cell_char;
  assign rsp.cell_attr      = out_word.cell_attr;
  assign rsp.cursor_row_out = out_word.cursor_row_out;
  assign rsp.cursor_col_out = out_word.cursor_col_out;

endmodule

`default_nettype wire
